// ----- design/mcsre_pkg.sv -----
// Shared types, codes, tables and helper functions of the ROM and RAM bus emulator.
`timescale 1ns / 1ps

package mcsre_pkg;

	// Default configuration.
	localparam int ROM_ADDR_BITS_DEF = 12;
	localparam int RAM_BANKS_DEF     = 8;
	localparam int REGS_PER_BANK_DEF = 16;

	// Depth of the queue between front and back, and of the result queue.
	localparam int FQ_DEPTH = 2;
	localparam int OQ_DEPTH = 4;

	// Number of CM-RAM bank codes the decoder can produce.
	localparam int CM_BANKS = 8;

	// Input operation codes.
	localparam logic [2:0] OP_PHI1 = 3'd0;
	localparam logic [2:0] OP_PHI2 = 3'd1;
	localparam logic [2:0] OP_RUN  = 3'd2;
	localparam logic [2:0] OP_STOP = 3'd3;
	localparam logic [2:0] OP_LOAD = 3'd4;

	// Classified word kinds.
	typedef enum logic [2:0] {
		K_NOP,
		K_PHI1,
		K_PHI2,
		K_RUN,
		K_STOP,
		K_LOAD
	} kind_t;

	// Bus stages.
	localparam logic [2:0] ST_A1 = 3'd0;
	localparam logic [2:0] ST_A2 = 3'd1;
	localparam logic [2:0] ST_A3 = 3'd2;
	localparam logic [2:0] ST_M1 = 3'd3;
	localparam logic [2:0] ST_M2 = 3'd4;
	localparam logic [2:0] ST_X1 = 3'd5;
	localparam logic [2:0] ST_X2 = 3'd6;
	localparam logic [2:0] ST_X3 = 3'd7;

	// Run modes.
	localparam logic [1:0] MODE_STALE     = 2'd0;
	localparam logic [1:0] MODE_RESETTING = 2'd1;
	localparam logic [1:0] MODE_RUNNING   = 2'd2;

	// RAM instruction opcodes.
	localparam logic [7:0] OPC_SBM = 8'hE8;
	localparam logic [7:0] OPC_RDM = 8'hE9;
	localparam logic [7:0] OPC_ADM = 8'hEB;
	localparam logic [7:0] OPC_RD0 = 8'hEC;
	localparam logic [7:0] OPC_RD3 = 8'hEF;
	localparam logic [7:0] OPC_WRM = 8'hE0;
	localparam logic [7:0] OPC_WMP = 8'hE1;
	localparam logic [7:0] OPC_WR0 = 8'hE4;
	localparam logic [7:0] OPC_WR3 = 8'hE7;

	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	// Source of the nibble driven on the bus.
	localparam logic [1:0] SEL_ROM_HI = 2'd0;
	localparam logic [1:0] SEL_ROM_LO = 2'd1;
	localparam logic [1:0] SEL_MAIN   = 2'd2;
	localparam logic [1:0] SEL_STAT   = 2'd3;

	// CM-RAM line code to bank number.
	localparam logic [2:0] CM_TO_BANK [16] = '{
		3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd4, 3'd0,
		3'd3, 3'd0, 3'd5, 3'd0, 3'd6, 3'd0, 3'd7, 3'd0
	};

	typedef struct packed {
		kind_t       kind;
		logic        sync;
		logic [3:0]  bus;
		logic [3:0]  cm;
		logic [11:0] laddr;
		logic [7:0]  lbyte;
	} item_t;

	typedef struct packed {
		logic       bus_drive;
		logic [3:0] bus_value;
		logic       reset_release;
		logic       port_write_valid;
		logic [3:0] port_write_data;
		logic [2:0] stage_now;
	} result_t;

	// Small modulo by a constant count, by repeated subtraction.
	function automatic logic [2:0] mod_bank(input logic [2:0] v, input int n);
		logic [3:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (int'(r) >= n) r = r - 4'(n);
		end
		return r[2:0];
	endfunction

	function automatic logic [3:0] mod_reg(input logic [3:0] v, input int n);
		logic [4:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 4; i++) begin
			if (int'(r) >= n) r = r - 5'(n);
		end
		return r[3:0];
	endfunction

	function automatic logic [2:0] bank_of(input logic [3:0] cm, input int n);
		return mod_bank(CM_TO_BANK[cm], n);
	endfunction

endpackage

// ----- design/mcs4_rom_ram_bus_cycle_emulator.sv -----
// Top level of the ROM and RAM bus-cycle emulator for a 4-bit CPU bus.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | op, sync_level, bus_nibble, cmram_lines, load_*
//  out     | out_valid / out_stall| bus_drive, bus_value, reset_release, port_write_*,
//          |                      | stage_now
//
// One word is taken per clock while in_stall is low; each accepted word yields
// exactly one result word via the input queue, execution with a registered RAM read
// and the result queue. The throughput is set by the execution stage, which handles
// one word a cycle while the result queue has room. After reset the main and status
// RAMs are swept to zero, one entry a cycle, over all RAM_BANKS*REGS_PER_BANK*16
// main entries (2048 by default); in_stall stays high during the sweep. A stalled
// output fills the result queue and then the input queue before in_stall rises.
`timescale 1ns / 1ps

module mcs4_rom_ram_bus_cycle_emulator #(
	parameter int ROM_ADDR_BITS = mcsre_pkg::ROM_ADDR_BITS_DEF,
	parameter int RAM_BANKS     = mcsre_pkg::RAM_BANKS_DEF,
	parameter int REGS_PER_BANK = mcsre_pkg::REGS_PER_BANK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic        sync_level,
	input  logic [3:0]  bus_nibble,
	input  logic [3:0]  cmram_lines,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        bus_drive,
	output logic [3:0]  bus_value,
	output logic        reset_release,
	output logic        port_write_valid,
	output logic [3:0]  port_write_data,
	output logic [2:0]  stage_now
);

	logic               item_valid, item_pop, room, clearing, res_valid;
	mcsre_pkg::item_t   item;
	mcsre_pkg::result_t res, out_word;

	// The front end classifies each input word and buffers it.
	mcsre_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.sync_level   (sync_level),
		.bus_nibble   (bus_nibble),
		.cmram_lines  (cmram_lines),
		.load_address (load_address),
		.load_byte    (load_byte),
		.hold         (clearing),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	// The back end runs the bus stage machine and owns the ROM and RAM arrays.
	mcsre_exec #(
		.ROM_ADDR_BITS (ROM_ADDR_BITS),
		.RAM_BANKS     (RAM_BANKS),
		.REGS_PER_BANK (REGS_PER_BANK)
	) u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.room       (room),
		.clearing   (clearing),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Results wait here so that a stalled consumer does not stop execution at once.
	mcsre_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_word)
	);

	assign bus_drive        = out_word.bus_drive;
	assign bus_value        = out_word.bus_value;
	assign reset_release    = out_word.reset_release;
	assign port_write_valid = out_word.port_write_valid;
	assign port_write_data  = out_word.port_write_data;
	assign stage_now        = out_word.stage_now;

endmodule

// ----- design/mcsre_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mcsre_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ----- design/mcsre_front.sv -----
// Front part: accepts input words, classifies them and queues them for the back part.
`timescale 1ns / 1ps

module mcsre_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          op,
	input  logic                sync_level,
	input  logic [3:0]          bus_nibble,
	input  logic [3:0]          cmram_lines,
	input  logic [11:0]         load_address,
	input  logic [7:0]          load_byte,
	input  logic                hold,
	output logic                item_valid,
	output mcsre_pkg::item_t    item,
	input  logic                item_pop
);

	localparam int PW = $clog2(mcsre_pkg::FQ_DEPTH);

	mcsre_pkg::item_t  fifo_q [mcsre_pkg::FQ_DEPTH];
	logic [PW-1:0]     wptr_q, rptr_q;
	logic [PW:0]       cnt_q;
	mcsre_pkg::item_t  cls;
	logic              push;

	always_comb begin
		case (op)
			mcsre_pkg::OP_PHI1: cls.kind = mcsre_pkg::K_PHI1;
			mcsre_pkg::OP_PHI2: cls.kind = mcsre_pkg::K_PHI2;
			mcsre_pkg::OP_RUN:  cls.kind = mcsre_pkg::K_RUN;
			mcsre_pkg::OP_STOP: cls.kind = mcsre_pkg::K_STOP;
			mcsre_pkg::OP_LOAD: cls.kind = mcsre_pkg::K_LOAD;
			default:            cls.kind = mcsre_pkg::K_NOP;
		endcase
		cls.sync  = sync_level;
		cls.bus   = bus_nibble;
		cls.cm    = cmram_lines;
		cls.laddr = load_address;
		cls.lbyte = load_byte;
	end

	assign in_stall   = hold || (cnt_q == (PW+1)'(mcsre_pkg::FQ_DEPTH));
	assign push       = in_valid && !in_stall;
	assign item_valid = (cnt_q != '0);
	assign item       = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (item_pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(item_pop);
		end
	end

endmodule

// ----- design/mcsre_outq.sv -----
// Result queue that decouples the back part from the output handshake.
`timescale 1ns / 1ps

module mcsre_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mcsre_pkg::result_t  push_data,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output mcsre_pkg::result_t  out_data
);

	localparam int PW = $clog2(mcsre_pkg::OQ_DEPTH);

	mcsre_pkg::result_t fifo_q [mcsre_pkg::OQ_DEPTH];
	logic [PW-1:0]      wptr_q, rptr_q;
	logic [PW:0]        cnt_q;
	logic               pop;

	// Room is counted against the entry already on its way in.
	assign room      = ((PW+1)'(cnt_q + (PW+1)'(push)) < (PW+1)'(mcsre_pkg::OQ_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = fifo_q[rptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

// ----- design/mcsre_exec.sv -----
// Back part: bus stage tracking, ROM fetch, RAM bank selection and RAM instruction execution.
`timescale 1ns / 1ps

module mcsre_exec #(
	parameter int ROM_ADDR_BITS = mcsre_pkg::ROM_ADDR_BITS_DEF,
	parameter int RAM_BANKS     = mcsre_pkg::RAM_BANKS_DEF,
	parameter int REGS_PER_BANK = mcsre_pkg::REGS_PER_BANK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  mcsre_pkg::item_t    item,
	output logic                item_pop,
	input  logic                room,
	output logic                clearing,
	output logic                res_valid,
	output mcsre_pkg::result_t  res
);

	localparam int MAIN_DEPTH = RAM_BANKS * REGS_PER_BANK * 16;
	localparam int STAT_DEPTH = RAM_BANKS * REGS_PER_BANK * 4;
	localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
	localparam int STAT_AW    = $clog2(STAT_DEPTH);
	localparam int ROM_DEPTH  = 1 << ROM_ADDR_BITS;

	logic [2:0]  stage_q, stage_d, next_q, next_d;
	logic [1:0]  mode_q, mode_d;
	logic [11:0] faddr_q, faddr_d;
	logic        fetched_q, fetched_d;
	logic        io_q, io_d, src_q, src_d;
	logic [3:0]  srcreg_q, srcreg_d;
	logic [2:0]  bank_q, bank_d;
	logic [3:0]  reg_q, reg_d, char_q, char_d;
	logic        drv_en_q, drv_en_d;
	logic [1:0]  drv_sel_q, drv_sel_d;
	logic        pin_q, pin_d;
	logic [3:0]  sv_reg_q [mcsre_pkg::CM_BANKS];
	logic [3:0]  sv_char_q [mcsre_pkg::CM_BANKS];
	logic        sv_we;

	logic        clr_q;
	logic [MAIN_AW-1:0] clr_addr_q;

	logic        valid_s1, pv_s1, pv_d;
	logic [3:0]  pd_s1, pd_d;

	logic        issue;
	logic [2:0]  cm_bank;
	logic [7:0]  opcode;
	logic [7:0]  rom_rdata;
	logic [3:0]  main_rdata, stat_rdata;
	logic        rom_re, rom_we, main_we, main_re, stat_we, stat_re;
	logic [MAIN_AW-1:0] main_idx;
	logic [STAT_AW-1:0] stat_idx;
	logic [3:0]  drv_val;

	assign clearing = clr_q;
	assign issue    = item_valid && room && !clr_q;
	assign item_pop = issue;
	assign cm_bank  = mcsre_pkg::bank_of(item.cm, RAM_BANKS);
	assign opcode   = fetched_q ? rom_rdata : 8'h00;
	assign main_idx = MAIN_AW'((int'(bank_q) * REGS_PER_BANK + int'(reg_q)) * 16
		+ int'(char_q));
	assign stat_idx = STAT_AW'((int'(bank_q) * REGS_PER_BANK + int'(reg_q)) * 4
		+ int'(opcode[1:0]));

	always_comb begin
		stage_d   = stage_q;
		next_d    = next_q;
		mode_d    = mode_q;
		faddr_d   = faddr_q;
		fetched_d = fetched_q;
		io_d      = io_q;
		src_d     = src_q;
		srcreg_d  = srcreg_q;
		bank_d    = bank_q;
		reg_d     = reg_q;
		char_d    = char_q;
		drv_en_d  = drv_en_q;
		drv_sel_d = drv_sel_q;
		pin_d     = pin_q;
		sv_we     = 1'b0;
		rom_re    = 1'b0;
		rom_we    = 1'b0;
		main_we   = 1'b0;
		main_re   = 1'b0;
		stat_we   = 1'b0;
		stat_re   = 1'b0;
		pv_d      = 1'b0;
		pd_d      = 4'd0;
		if (issue) begin
			case (item.kind)
				mcsre_pkg::K_PHI1: begin
					if (item.sync) begin
						stage_d = mcsre_pkg::ST_X3;
						next_d  = mcsre_pkg::ST_A1;
						if (src_q) begin
							reg_d  = mcsre_pkg::mod_reg(srcreg_q, REGS_PER_BANK);
							char_d = item.bus;
							sv_we  = 1'b1;
						end
					end else begin
						case (stage_q)
							mcsre_pkg::ST_A1: begin
								faddr_d = {8'd0, item.bus};
								next_d  = mcsre_pkg::ST_A2;
							end
							mcsre_pkg::ST_A2: begin
								faddr_d = faddr_q | {4'd0, item.bus, 4'd0};
								next_d  = mcsre_pkg::ST_A3;
							end
							mcsre_pkg::ST_A3: begin
								faddr_d = faddr_q | {item.bus, 8'd0};
								next_d  = mcsre_pkg::ST_M1;
							end
							mcsre_pkg::ST_M1: begin
								next_d = mcsre_pkg::ST_M2;
							end
							mcsre_pkg::ST_M2: begin
								if (item.cm != 4'd0) begin
									bank_d = cm_bank;
									reg_d  = sv_reg_q[cm_bank];
									char_d = sv_char_q[cm_bank];
									io_d   = 1'b1;
								end else begin
									io_d = 1'b0;
								end
								next_d = mcsre_pkg::ST_X1;
							end
							mcsre_pkg::ST_X1: begin
								drv_en_d = 1'b0;
								next_d   = mcsre_pkg::ST_X2;
							end
							mcsre_pkg::ST_X2: begin
								next_d = mcsre_pkg::ST_X3;
								if (mode_q == mcsre_pkg::MODE_RESETTING) begin
									pin_d  = 1'b1;
									mode_d = mcsre_pkg::MODE_RUNNING;
								end else if (item.cm != 4'd0) begin
									srcreg_d = item.bus;
									bank_d   = cm_bank;
									src_d    = 1'b1;
								end else begin
									if (io_q) begin
										if (opcode == mcsre_pkg::OPC_WRM) begin
											main_we = 1'b1;
										end else if (opcode inside
											{[mcsre_pkg::OPC_WR0:mcsre_pkg::OPC_WR3]}) begin
											stat_we = 1'b1;
										end else if (opcode == mcsre_pkg::OPC_WMP) begin
											pv_d = 1'b1;
											pd_d = item.bus;
										end
									end
									src_d = 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				mcsre_pkg::K_PHI2: begin
					if (mode_q == mcsre_pkg::MODE_RUNNING) begin
						case (stage_q)
							mcsre_pkg::ST_A3: begin
								rom_re    = 1'b1;
								fetched_d = 1'b1;
								drv_en_d  = 1'b1;
								drv_sel_d = mcsre_pkg::SEL_ROM_HI;
							end
							mcsre_pkg::ST_M1: begin
								drv_en_d  = 1'b1;
								drv_sel_d = mcsre_pkg::SEL_ROM_LO;
							end
							mcsre_pkg::ST_X1: begin
								if (io_q) begin
									if (opcode inside {mcsre_pkg::OPC_SBM, mcsre_pkg::OPC_RDM,
										mcsre_pkg::OPC_ADM}) begin
										main_re   = 1'b1;
										drv_en_d  = 1'b1;
										drv_sel_d = mcsre_pkg::SEL_MAIN;
									end else if (opcode inside
										{[mcsre_pkg::OPC_RD0:mcsre_pkg::OPC_RD3]}) begin
										stat_re   = 1'b1;
										drv_en_d  = 1'b1;
										drv_sel_d = mcsre_pkg::SEL_STAT;
									end
								end
							end
							mcsre_pkg::ST_X3: begin
								drv_en_d = 1'b0;
							end
							default: begin
							end
						endcase
					end
					stage_d = next_q;
				end
				mcsre_pkg::K_RUN: begin
					mode_d = mcsre_pkg::MODE_RESETTING;
				end
				mcsre_pkg::K_STOP: begin
					pin_d  = 1'b0;
					mode_d = mcsre_pkg::MODE_STALE;
				end
				mcsre_pkg::K_LOAD: begin
					rom_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	mcsre_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
		.clk   (clk),
		.we    (rom_we),
		.waddr (item.laddr[ROM_ADDR_BITS-1:0]),
		.wdata (item.lbyte),
		.re    (rom_re),
		.raddr (faddr_q[ROM_ADDR_BITS-1:0]),
		.rdata (rom_rdata)
	);

	mcsre_ram #(.WIDTH(4), .DEPTH(MAIN_DEPTH)) u_main (
		.clk   (clk),
		.we    (main_we || clr_q),
		.waddr (clr_q ? clr_addr_q : main_idx),
		.wdata (clr_q ? 4'd0 : item.bus),
		.re    (main_re),
		.raddr (main_idx),
		.rdata (main_rdata)
	);

	mcsre_ram #(.WIDTH(4), .DEPTH(STAT_DEPTH)) u_stat (
		.clk   (clk),
		.we    (stat_we || (clr_q && (int'(clr_addr_q) < STAT_DEPTH))),
		.waddr (clr_q ? clr_addr_q[STAT_AW-1:0] : stat_idx),
		.wdata (clr_q ? 4'd0 : item.bus),
		.re    (stat_re),
		.raddr (stat_idx),
		.rdata (stat_rdata)
	);

	always_ff @(posedge clk) begin
		pv_s1 <= pv_d;
		pd_s1 <= pd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q    <= mcsre_pkg::ST_X3;
			next_q     <= mcsre_pkg::ST_A1;
			mode_q     <= mcsre_pkg::MODE_STALE;
			faddr_q    <= '0;
			fetched_q  <= 1'b0;
			io_q       <= 1'b0;
			src_q      <= 1'b0;
			srcreg_q   <= '0;
			bank_q     <= '0;
			reg_q      <= '0;
			char_q     <= '0;
			drv_en_q   <= 1'b0;
			drv_sel_q  <= mcsre_pkg::SEL_ROM_HI;
			pin_q      <= 1'b0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
			for (int i = 0; i < mcsre_pkg::CM_BANKS; i++) begin
				sv_reg_q[i]  <= '0;
				sv_char_q[i] <= '0;
			end
		end else begin
			stage_q   <= stage_d;
			next_q    <= next_d;
			mode_q    <= mode_d;
			faddr_q   <= faddr_d;
			fetched_q <= fetched_d;
			io_q      <= io_d;
			src_q     <= src_d;
			srcreg_q  <= srcreg_d;
			bank_q    <= bank_d;
			reg_q     <= reg_d;
			char_q    <= char_d;
			drv_en_q  <= drv_en_d;
			drv_sel_q <= drv_sel_d;
			pin_q     <= pin_d;
			valid_s1  <= issue;
			if (sv_we) begin
				sv_reg_q[bank_q]  <= reg_d;
				sv_char_q[bank_q] <= char_d;
			end
			if (clr_q) begin
				if (int'(clr_addr_q) == MAIN_DEPTH - 1) clr_q <= 1'b0;
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// The saved bank registers are flops with an asynchronous reset, so the
	// sweep only has to cover the two RAMs.
	always_comb begin
		case (drv_sel_q)
			mcsre_pkg::SEL_ROM_HI: drv_val = opcode[7:4];
			mcsre_pkg::SEL_ROM_LO: drv_val = opcode[3:0] & mcsre_pkg::NIBBLE_MASK;
			mcsre_pkg::SEL_MAIN:   drv_val = main_rdata;
			mcsre_pkg::SEL_STAT:   drv_val = stat_rdata;
			default:               drv_val = 4'd0;
		endcase
	end

	assign res_valid            = valid_s1;
	assign res.bus_drive        = drv_en_q;
	assign res.bus_value        = drv_en_q ? drv_val : 4'd0;
	assign res.reset_release    = pin_q;
	assign res.port_write_valid = pv_s1;
	assign res.port_write_data  = pv_s1 ? pd_s1 : 4'd0;
	assign res.stage_now        = stage_q;

endmodule

// ----- design/mcsre_checker.sv -----
// Port-level checks of the bus emulator, bound to its top level.
`timescale 1ns / 1ps

module mcsre_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       bus_drive,
	input logic [3:0] bus_value,
	input logic       port_write_valid,
	input logic [3:0] port_write_data,
	input logic [2:0] stage_now
);

	// A word that is stalled stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word withdrawn while stalled");

	// A released bus reports a zero nibble.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bus_drive |-> bus_value == 4'd0)
		else $error("bus value nonzero while released");

	// Port data is zero unless a port write happened.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !port_write_valid |-> port_write_data == 4'd0)
		else $error("port data without port write");

	// Port writes happen only during the X2 stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && port_write_valid |-> stage_now == mcsre_pkg::ST_X2)
		else $error("port write outside X2");

	// The bus is not driven during a port write in stage X2, where writes are sampled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stage_now == mcsre_pkg::ST_X2 && port_write_valid |-> !bus_drive)
		else $error("bus driven during a port write");

endmodule

bind mcs4_rom_ram_bus_cycle_emulator mcsre_checker u_mcsre_checker (.*);

// ----- dv/mcs4_emu_checker.sv -----
// Checker for the ROM and RAM bus emulator: predicts every result word and compares.
`timescale 1ns / 1ps

module mcs4_emu_checker #(
	parameter int RAM_BANKS     = mcsre_pkg::RAM_BANKS_DEF,
	parameter int REGS_PER_BANK = mcsre_pkg::REGS_PER_BANK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  op,
	input  logic        sync_level,
	input  logic [3:0]  bus_nibble,
	input  logic [3:0]  cmram_lines,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        bus_drive,
	input  logic [3:0]  bus_value,
	input  logic        reset_release,
	input  logic        port_write_valid,
	input  logic [3:0]  port_write_data,
	input  logic [2:0]  stage_now,
	output int          fail_count,
	output int          pending_words
);

	logic [2:0]  cur_stage, next_stage;
	logic [1:0]  mode;
	logic [11:0] faddr;
	logic [7:0]  opc;
	logic        io_on, src_on;
	logic [3:0]  src_reg, act_reg, act_char;
	logic [2:0]  act_bank;
	logic [3:0]  saved_reg [8];
	logic [3:0]  saved_char [8];
	logic [3:0]  main_ram [2048];
	logic [3:0]  stat_ram [512];
	logic [7:0]  rom [4096];
	logic        drv_en, port_v, cpu_run;
	logic [3:0]  drv_val, port_d;

	mcsre_pkg::result_t expected_words [$];

	initial begin
		fail_count = 0;
		pending_words = 0;
		cur_stage = mcsre_pkg::ST_X3; next_stage = mcsre_pkg::ST_A1;
		mode = mcsre_pkg::MODE_STALE;
		faddr = '0; opc = '0; io_on = 0; src_on = 0;
		src_reg = '0; act_reg = '0; act_char = '0; act_bank = '0;
		drv_en = 0; drv_val = '0; cpu_run = 0; port_v = 0; port_d = '0;
		for (int i = 0; i < 8; i++) begin
			saved_reg[i] = '0; saved_char[i] = '0;
		end
		foreach (main_ram[i]) main_ram[i] = '0;
		foreach (stat_ram[i]) stat_ram[i] = '0;
		foreach (rom[i]) rom[i] = '0;
	end

	function automatic int main_addr();
		return ((int'(act_bank) % RAM_BANKS) * REGS_PER_BANK
			+ int'(act_reg) % REGS_PER_BANK) * 16 + int'(act_char);
	endfunction

	function automatic int stat_addr(input logic [1:0] k);
		return ((int'(act_bank) % RAM_BANKS) * REGS_PER_BANK
			+ int'(act_reg) % REGS_PER_BANK) * 4 + int'(k);
	endfunction

	function automatic logic [2:0] cm_bank(input logic [3:0] cm);
		return 3'(int'(mcsre_pkg::CM_TO_BANK[cm]) % RAM_BANKS);
	endfunction

	task automatic phi1_edge(input logic s, input logic [3:0] b, input logic [3:0] cm);
		logic [7:0] wop;
		if (s) begin
			cur_stage = mcsre_pkg::ST_X3;
			if (src_on) begin
				act_reg = 4'(int'(src_reg) % REGS_PER_BANK);
				act_char = b;
				saved_reg[act_bank] = act_reg;
				saved_char[act_bank] = act_char;
			end
			next_stage = mcsre_pkg::ST_A1;
			return;
		end
		case (cur_stage)
			mcsre_pkg::ST_A1: begin faddr = {8'h0, b}; next_stage = mcsre_pkg::ST_A2; end
			mcsre_pkg::ST_A2: begin
				faddr = faddr | {4'h0, b, 4'h0}; next_stage = mcsre_pkg::ST_A3;
			end
			mcsre_pkg::ST_A3: begin
				faddr = faddr | {b, 8'h0}; next_stage = mcsre_pkg::ST_M1;
			end
			mcsre_pkg::ST_M1: next_stage = mcsre_pkg::ST_M2;
			mcsre_pkg::ST_M2: begin
				if (cm != 0) begin
					act_bank = cm_bank(cm);
					act_reg = saved_reg[act_bank];
					act_char = saved_char[act_bank];
					io_on = 1;
				end else begin
					io_on = 0;
				end
				next_stage = mcsre_pkg::ST_X1;
			end
			mcsre_pkg::ST_X1: begin drv_en = 0; next_stage = mcsre_pkg::ST_X2; end
			mcsre_pkg::ST_X2: begin
				next_stage = mcsre_pkg::ST_X3;
				if (mode == mcsre_pkg::MODE_RESETTING) begin
					cpu_run = 1;
					mode = mcsre_pkg::MODE_RUNNING;
				end else if (cm != 0) begin
					// An SRC: the register number rides on the bus at X2.
					src_reg = b;
					act_bank = cm_bank(cm);
					src_on = 1;
				end else begin
					if (io_on) begin
						wop = opc;
						if (wop == mcsre_pkg::OPC_WRM) main_ram[main_addr()] = b;
						else if (wop >= mcsre_pkg::OPC_WR0 && wop <= mcsre_pkg::OPC_WR3)
							stat_ram[stat_addr(2'(wop - mcsre_pkg::OPC_WR0))] = b;
						else if (wop == mcsre_pkg::OPC_WMP) begin
							port_v = 1; port_d = b;
						end
					end
					src_on = 0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic phi2_edge();
		if (mode == mcsre_pkg::MODE_RUNNING) begin
			case (cur_stage)
				mcsre_pkg::ST_A3: begin
					opc = rom[faddr];
					drv_en = 1; drv_val = opc[7:4];
				end
				mcsre_pkg::ST_M1: begin drv_en = 1; drv_val = opc[3:0]; end
				mcsre_pkg::ST_X1: if (io_on) begin
					if (opc == mcsre_pkg::OPC_SBM || opc == mcsre_pkg::OPC_RDM
						|| opc == mcsre_pkg::OPC_ADM) begin
						drv_en = 1; drv_val = main_ram[main_addr()];
					end else if (opc >= mcsre_pkg::OPC_RD0 && opc <= mcsre_pkg::OPC_RD3) begin
						drv_en = 1;
						drv_val = stat_ram[stat_addr(2'(opc - mcsre_pkg::OPC_RD0))];
					end
				end
				mcsre_pkg::ST_X3: drv_en = 0;
				default: ;
			endcase
		end
		cur_stage = next_stage;
	endtask

	task automatic predict_word();
		mcsre_pkg::result_t r;
		port_v = 0; port_d = '0;
		case (op)
			mcsre_pkg::OP_PHI1: phi1_edge(sync_level, bus_nibble, cmram_lines);
			mcsre_pkg::OP_PHI2: phi2_edge();
			mcsre_pkg::OP_RUN:  mode = mcsre_pkg::MODE_RESETTING;
			mcsre_pkg::OP_STOP: begin cpu_run = 0; mode = mcsre_pkg::MODE_STALE; end
			mcsre_pkg::OP_LOAD: rom[load_address] = load_byte;
			default: ;
		endcase
		r.bus_drive = drv_en;
		r.bus_value = drv_en ? drv_val : 4'h0;
		r.reset_release = cpu_run;
		r.port_write_valid = port_v;
		r.port_write_data = port_v ? port_d : 4'h0;
		r.stage_now = cur_stage;
		expected_words.push_back(r);
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("checker: %s mismatch at %0t, got %0d expected %0d", what, $realtime, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		mcsre_pkg::result_t e;
		if (arst_n) begin
			if (in_valid && !in_stall) predict_word();
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("checker: result word with nothing expected at %0t", $realtime);
					fail_count++;
				end else begin
					e = expected_words.pop_front();
					if (bus_drive !== e.bus_drive) report("bus_drive", bus_drive, e.bus_drive);
					if (bus_value !== e.bus_value) report("bus_value", bus_value, e.bus_value);
					if (reset_release !== e.reset_release)
						report("reset_release", reset_release, e.reset_release);
					if (port_write_valid !== e.port_write_valid)
						report("port_write_valid", port_write_valid, e.port_write_valid);
					if (port_write_data !== e.port_write_data)
						report("port_write_data", port_write_data, e.port_write_data);
					if (stage_now !== e.stage_now) report("stage_now", stage_now, e.stage_now);
				end
			end
			pending_words <= expected_words.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Top of the bench: clock, reset, bus-cycle stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module testbench;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic        sync_level = 0;
	logic [3:0]  bus_nibble = '0;
	logic [3:0]  cmram_lines = '0;
	logic [11:0] load_address = '0;
	logic [7:0]  load_byte = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        bus_drive;
	logic [3:0]  bus_value;
	logic        reset_release;
	logic        port_write_valid;
	logic [3:0]  port_write_data;
	logic [2:0]  stage_now;
	int          fail_count;
	int          pending_words;
	int          cycle_count = 0;
	int          random_words = 0;
	bit          hold_done = 0;

	localparam int CYCLE_LIMIT = 600000;
	// Fetches stay inside the low ROM window, plus the top address used once.
	localparam int ROM_SPAN = 64;

	always #2 clk = ~clk;

	mcs4_rom_ram_bus_cycle_emulator i_dut (.*);

	mcs4_emu_checker i_checker (.*);

	// Gap lengths: mostly none, sometimes short, rarely a long pause.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Most ROM bytes are RAM instructions so that reads and writes happen often.
	function automatic logic [7:0] rom_byte();
		return ($urandom_range(9) < 7) ? {4'hE, 4'($urandom)} : 8'($urandom);
	endfunction

	// Offer one word and hold it until the block accepts it. Called at a rising
	// edge; it returns at an edge where in_stall is seen low, or at the end of a
	// random gap after it. Fields that the operation ignores still get random values.
	task automatic send_word(input logic [2:0] o, input logic s, input logic [3:0] b,
			input logic [3:0] cm, input logic [11:0] la, input logic [7:0] lb);
		int g;
		in_valid <= 1;
		op <= o; sync_level <= s; bus_nibble <= b; cmram_lines <= cm;
		load_address <= la; load_byte <= lb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_phi1(input logic s, input logic [3:0] b, input logic [3:0] cm);
		send_word(mcsre_pkg::OP_PHI1, s, b, cm, 12'($urandom), 8'($urandom));
	endtask

	task automatic send_phi2();
		send_word(mcsre_pkg::OP_PHI2, 1'($urandom), 4'($urandom), 4'($urandom),
			12'($urandom), 8'($urandom));
	endtask

	task automatic send_ctrl(input logic [2:0] o);
		send_word(o, 1'($urandom), 4'($urandom), 4'($urandom), 12'($urandom), 8'($urandom));
	endtask

	// One complete bus cycle, A1 through X3, closed by SYNC. The CM-RAM lines
	// select a bank at M2 most of the time and mark an SRC at X2 now and then.
	task automatic bus_cycle(input logic [3:0] a1, input logic [3:0] a2, input logic [3:0] a3);
		logic [3:0] cm_m2, cm_x2;
		cm_m2 = ($urandom_range(9) < 7) ? 4'($urandom_range(15, 1)) : 4'h0;
		cm_x2 = ($urandom_range(9) < 3) ? 4'($urandom_range(15, 1)) : 4'h0;
		send_phi1(0, a1, 4'($urandom)); send_phi2();
		send_phi1(0, a2, 4'($urandom)); send_phi2();
		send_phi1(0, a3, 4'($urandom)); send_phi2();
		send_phi1(0, 4'($urandom), 4'($urandom)); send_phi2();
		send_phi1(0, 4'($urandom), cm_m2); send_phi2();
		send_phi1(0, 4'($urandom), 4'($urandom)); send_phi2();
		send_phi1(0, 4'($urandom), cm_x2); send_phi2();
		send_phi1(1, 4'($urandom), 4'($urandom)); send_phi2();
	endtask

	// The receiver: random stalls, plus one long hold-off while the sender keeps
	// offering words, so that both queues fill and the input stalls.
	initial begin
		int g, hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && cycle_count > 4000) begin
				hold_done = 1;
				out_stall <= 1;
				hold = 0;
				while (hold < 300) begin
					@(posedge clk);
					hold++;
				end
				out_stall <= 0;
			end else begin
				g = gap_len();
				if (g > 0) begin
					out_stall <= 1;
					repeat (g) @(posedge clk);
					out_stall <= 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int p;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Load the ROM window that fetches use, and the top address.
		for (int a = 0; a < ROM_SPAN; a++)
			send_word(mcsre_pkg::OP_LOAD, 1'($urandom), 4'($urandom), 4'($urandom),
				12'(a), rom_byte());
		send_word(mcsre_pkg::OP_LOAD, 1'($urandom), 4'($urandom), 4'($urandom),
			12'hFFF, rom_byte());

		// Directed words: unused codes, stop, X3 without SYNC, a repeated phi1,
		// a cycle while not running, then a run request taken at X2.
		for (int c = int'(mcsre_pkg::OP_LOAD) + 1; c < 8; c++) send_ctrl(3'(c));
		send_ctrl(mcsre_pkg::OP_STOP);
		send_phi1(0, 4'hF, 4'hF);
		send_phi1(1, 4'h0, 4'h0); send_phi2();
		send_phi1(0, 4'hF, 4'h0); send_phi1(0, 4'h0, 4'h0); send_phi2();
		send_ctrl(mcsre_pkg::OP_RUN);
		bus_cycle(4'h0, 4'h0, 4'h0);
		bus_cycle(4'hF, 4'hF, 4'hF);

		// Random part: mostly well-formed bus cycles, the rest noise. Noise never
		// carries a clock-phase edge, so every bus cycle stays in step and its
		// fetch address stays inside the loaded window.
		while (random_words < 1670) begin
			p = $urandom_range(99);
			if (p < 8) begin
				send_ctrl(mcsre_pkg::OP_RUN); random_words++;
			end else if (p < 10) begin
				send_ctrl(mcsre_pkg::OP_STOP); random_words++;
			end else if (p < 18) begin
				send_ctrl(3'($urandom_range(7, int'(mcsre_pkg::OP_RUN)))); random_words++;
			end else if (p < 20) begin
				send_word(mcsre_pkg::OP_LOAD, 1'($urandom), 4'($urandom), 4'($urandom),
					12'($urandom), 8'($urandom));
				random_words++;
			end else begin
				bus_cycle(4'($urandom), 4'($urandom_range(3)), 4'h0);
				random_words += 16;
			end
		end
		in_valid <= 0;

		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/mcsre_pkg.sv
design/mcsre_ram.sv
design/mcsre_front.sv
design/mcsre_outq.sv
design/mcsre_exec.sv
design/mcs4_rom_ram_bus_cycle_emulator.sv
design/mcsre_checker.sv
dv/mcs4_emu_checker.sv
dv/testbench.sv
